@@ sv/slab_pkg.sv @@
// Shared types, constants and class tables for the slab block allocator.
// Used by every module of the block; depends on nothing.
package slab_pkg;

    localparam int NUM_PAGES   = 64;
    localparam int PAGE_W      = 6;
    localparam int PAGE_BYTES  = 4096;
    localparam int OFS_W       = 12;
    localparam int HDR_BYTES   = 40;
    localparam int MAX_ALLOC   = 64;
    localparam int NUM_CLASSES = 6;
    localparam int CLS_W       = 3;
    localparam int IDX_W       = 9;
    localparam int ADDR_W      = 18;
    localparam int BLK_AW      = PAGE_W + IDX_W;
    localparam int TAKEN_W     = PAGE_W + 1;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_PAGE   = 2'd2,
        ST_BAD_ADDR  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_DEC,
        BS_RD,
        BS_WORK,
        BS_LINK
    } t_bstate;

    typedef struct packed {
        logic [1:0]        action;
        logic [7:0]        size;
        logic [ADDR_W-1:0] address;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] block_address;
        logic              owned;
        logic [6:0]        block_bytes;
    } t_out;

    typedef struct packed {
        t_action           action;
        logic              size_bad;
        logic [CLS_W-1:0]  cls;
        logic [PAGE_W-1:0] page;
        logic [OFS_W-1:0]  offset;
    } t_cmd;

    typedef struct packed {
        logic              link_valid;
        logic [PAGE_W-1:0] link;
        logic [CLS_W-1:0]  cls;
        logic [IDX_W-1:0]  free_top;
        logic [IDX_W-1:0]  cursor;
        logic [IDX_W-1:0]  count;
    } t_prec;

    function automatic logic [CLS_W-1:0] size_to_class(input logic [7:0] size);
        logic [CLS_W-1:0] c;
        if (size <= 8'd8)       c = 3'd0;
        else if (size <= 8'd16) c = 3'd1;
        else if (size <= 8'd24) c = 3'd2;
        else if (size <= 8'd32) c = 3'd3;
        else if (size <= 8'd48) c = 3'd4;
        else                    c = 3'd5;
        return c;
    endfunction

    function automatic logic [6:0] class_bytes(input logic [CLS_W-1:0] cls);
        logic [6:0] b;
        case (cls)
            3'd0:    b = 7'd8;
            3'd1:    b = 7'd16;
            3'd2:    b = 7'd24;
            3'd3:    b = 7'd32;
            3'd4:    b = 7'd48;
            default: b = 7'd64;
        endcase
        return b;
    endfunction

    // (PAGE_BYTES - HDR_BYTES) / class size
    function automatic logic [IDX_W-1:0] blocks_in_page(input logic [CLS_W-1:0] cls);
        logic [IDX_W-1:0] n;
        case (cls)
            3'd0:    n = 9'd507;
            3'd1:    n = 9'd253;
            3'd2:    n = 9'd169;
            3'd3:    n = 9'd126;
            3'd4:    n = 9'd84;
            default: n = 9'd63;
        endcase
        return n;
    endfunction

endpackage

@@ sv/slab_front.sv @@
// Front part: accepts items, classifies them and holds them in a two-entry queue.
// Depends on slab_pkg.
module slab_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  slab_pkg::t_in   i_item,
    output logic            o_cmd_valid,
    input  logic            i_cmd_pop,
    output slab_pkg::t_cmd  o_cmd
);

    slab_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           w_push;
    slab_pkg::t_cmd w_cmd;

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        w_cmd.action   = slab_pkg::t_action'(i_item.action);
        w_cmd.size_bad = (i_item.size > 8'(slab_pkg::MAX_ALLOC));
        w_cmd.cls      = slab_pkg::size_to_class(i_item.size);
        w_cmd.page     = i_item.address[slab_pkg::ADDR_W-1:slab_pkg::OFS_W];
        w_cmd.offset   = i_item.address[slab_pkg::OFS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, i_cmd_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ sv/slab_back.sv @@
// Back part: carries out allocate, free and query against the class lists,
// the page record memory and the block link memory. Depends on slab_pkg.
module slab_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    output logic            o_cmd_pop,
    input  slab_pkg::t_cmd  i_cmd,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output slab_pkg::t_out  o_out
);

    localparam int PW = slab_pkg::PAGE_W;
    localparam int IW = slab_pkg::IDX_W;
    localparam int CW = slab_pkg::CLS_W;
    localparam int AW = slab_pkg::ADDR_W;
    localparam int OFS_W_L = slab_pkg::OFS_W;

    slab_pkg::t_bstate r_state, n_state;
    slab_pkg::t_cmd    r_cmd;
    slab_pkg::t_prec   r_rec, n_rec;
    logic              rec_load;
    logic [PW-1:0]     r_page, n_page;
    logic              r_from_list, n_from_list;
    logic [slab_pkg::TAKEN_W-1:0] r_pages_taken;
    logic              taken_inc;
    logic [PW-1:0]     r_head   [slab_pkg::NUM_CLASSES];
    logic              r_head_v [slab_pkg::NUM_CLASSES];
    logic              head_we;
    logic [CW-1:0]     head_cls;
    logic [PW-1:0]     head_val;
    logic              head_vval;
    logic              r_out_valid;
    slab_pkg::t_out    r_out, n_out;
    logic              out_load;
    logic              out_free;

    // page record and block link memories
    slab_pkg::t_prec   m_prec [slab_pkg::NUM_PAGES];
    slab_pkg::t_prec   r_prec_q, prec_wdata;
    logic              prec_we, prec_re;
    logic [PW-1:0]     prec_raddr;
    logic [IW-1:0]     m_blk [1 << slab_pkg::BLK_AW];
    logic [IW-1:0]     r_blk_q, blk_wdata;
    logic              blk_we, blk_re;
    logic [slab_pkg::BLK_AW-1:0] blk_waddr, blk_raddr;

    // datapath views of the current page
    logic [CW-1:0]     w_cls;
    logic [6:0]        w_esize;
    logic [IW-1:0]     w_blocks;
    logic              w_has_freed;
    logic [OFS_W_L-1:0] w_rel;
    logic [IW-1:0]     w_fidx;
    logic              w_falign;
    logic [IW-1:0]     w_q8;
    logic [IW-1:0]     w_q3;
    logic [17:0]       w_prod3;
    logic              w_free_ok;
    logic [IW-1:0]     w_aidx;
    logic [15:0]       w_aoff;
    logic [AW-1:0]     w_aaddr;
    logic [PW-1:0]     w_h;
    logic              w_hv;
    logic [IW-1:0]     w_cnt_dec;
    logic              w_taken_full;
    logic              w_page_out;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cmd_pop   = (r_state == slab_pkg::BS_IDLE) && i_cmd_valid;

    assign w_taken_full = (r_pages_taken >= slab_pkg::TAKEN_W'(slab_pkg::NUM_PAGES));
    assign w_page_out   = ({1'b0, r_cmd.page} >= r_pages_taken);

    assign w_cls = (r_rec.cls >= CW'(slab_pkg::NUM_CLASSES)) ?
                   r_rec.cls - CW'(slab_pkg::NUM_CLASSES) : r_rec.cls;
    assign w_esize  = slab_pkg::class_bytes(w_cls);
    assign w_blocks = slab_pkg::blocks_in_page(w_cls);
    assign w_has_freed = ({1'b0, r_rec.count} + {1'b0, r_rec.cursor}) > {1'b0, w_blocks};
    assign w_rel = r_cmd.offset - OFS_W_L'(slab_pkg::HDR_BYTES);

    // block index of a freed address; classes 24 and 48 divide by 3 via 171/512
    always_comb begin
        w_q8     = (w_cls == 3'd4) ? {1'b0, w_rel[11:4]} : w_rel[11:3];
        w_prod3  = w_q8 * 9'd171;
        w_q3     = w_prod3[17:9];
        case (w_cls)
            3'd0: begin
                w_fidx   = w_rel[11:3];
                w_falign = (w_rel[2:0] == 3'd0);
            end
            3'd1: begin
                w_fidx   = {1'b0, w_rel[11:4]};
                w_falign = (w_rel[3:0] == 4'd0);
            end
            3'd3: begin
                w_fidx   = {2'b0, w_rel[11:5]};
                w_falign = (w_rel[4:0] == 5'd0);
            end
            3'd2: begin
                w_fidx   = w_q3;
                w_falign = (w_rel[2:0] == 3'd0) && (w_q8 == IW'(w_q3 * 2'd3));
            end
            3'd4: begin
                w_fidx   = w_q3;
                w_falign = (w_rel[3:0] == 4'd0) && (w_q8 == IW'(w_q3 * 2'd3));
            end
            default: begin
                w_fidx   = {3'b0, w_rel[11:6]};
                w_falign = (w_rel[5:0] == 6'd0);
            end
        endcase
    end

    assign w_free_ok = (r_cmd.offset >= OFS_W_L'(slab_pkg::HDR_BYTES)) && w_falign &&
                       (w_fidx < r_rec.cursor) && (r_rec.count < w_blocks);

    assign w_aidx  = (r_state == slab_pkg::BS_LINK) ? r_rec.free_top : r_rec.cursor;
    assign w_aoff  = 16'(w_aidx * w_esize);
    assign w_aaddr = {r_page, {slab_pkg::OFS_W{1'b0}}} + AW'(slab_pkg::HDR_BYTES) + AW'(w_aoff);
    assign w_h     = r_from_list ? r_rec.link : r_head[w_cls];
    assign w_hv    = r_from_list ? r_rec.link_valid : r_head_v[w_cls];
    assign w_cnt_dec = r_rec.count - IW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            slab_pkg::BS_IDLE: begin
                if (i_cmd_valid) n_state = slab_pkg::BS_DEC;
            end
            slab_pkg::BS_DEC: begin
                case (r_cmd.action)
                    slab_pkg::ACT_ALLOC: begin
                        if (r_cmd.size_bad) begin
                            if (out_free) n_state = slab_pkg::BS_IDLE;
                        end else if (r_head_v[r_cmd.cls]) begin
                            n_state = slab_pkg::BS_RD;
                        end else if (w_taken_full) begin
                            if (out_free) n_state = slab_pkg::BS_IDLE;
                        end else begin
                            n_state = slab_pkg::BS_WORK;
                        end
                    end
                    slab_pkg::ACT_FREE, slab_pkg::ACT_QUERY: begin
                        if (w_page_out) begin
                            if (out_free) n_state = slab_pkg::BS_IDLE;
                        end else begin
                            n_state = slab_pkg::BS_RD;
                        end
                    end
                    default: begin
                        if (out_free) n_state = slab_pkg::BS_IDLE;
                    end
                endcase
            end
            slab_pkg::BS_RD: n_state = slab_pkg::BS_WORK;
            slab_pkg::BS_WORK: begin
                if (r_cmd.action == slab_pkg::ACT_ALLOC && w_has_freed) begin
                    n_state = slab_pkg::BS_LINK;
                end else if (out_free) begin
                    n_state = slab_pkg::BS_IDLE;
                end
            end
            slab_pkg::BS_LINK: begin
                if (out_free) n_state = slab_pkg::BS_IDLE;
            end
            default: n_state = slab_pkg::BS_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_rec       = r_rec;
        rec_load    = 1'b0;
        n_page      = r_page;
        n_from_list = r_from_list;
        taken_inc   = 1'b0;
        head_we     = 1'b0;
        head_cls    = w_cls;
        head_val    = w_h;
        head_vval   = w_hv;
        n_out       = '0;
        out_load    = 1'b0;
        prec_re     = 1'b0;
        prec_raddr  = r_cmd.page;
        prec_we     = 1'b0;
        prec_wdata  = r_rec;
        blk_re      = 1'b0;
        blk_raddr   = {r_page, r_rec.free_top};
        blk_we      = 1'b0;
        blk_waddr   = {r_page, w_fidx};
        blk_wdata   = r_rec.free_top;
        case (r_state)
            slab_pkg::BS_DEC: begin
                case (r_cmd.action)
                    slab_pkg::ACT_ALLOC: begin
                        if (r_cmd.size_bad) begin
                            n_out.status = slab_pkg::ST_TOO_LARGE;
                            out_load     = out_free;
                        end else if (r_head_v[r_cmd.cls]) begin
                            prec_re     = 1'b1;
                            prec_raddr  = r_head[r_cmd.cls];
                            n_page      = r_head[r_cmd.cls];
                            n_from_list = 1'b1;
                        end else if (w_taken_full) begin
                            n_out.status = slab_pkg::ST_NO_PAGE;
                            out_load     = out_free;
                        end else begin
                            // take a fresh page
                            n_page           = r_pages_taken[PW-1:0];
                            n_from_list      = 1'b0;
                            taken_inc        = 1'b1;
                            rec_load         = 1'b1;
                            n_rec.link_valid = 1'b0;
                            n_rec.link       = '0;
                            n_rec.cls        = r_cmd.cls;
                            n_rec.free_top   = '0;
                            n_rec.cursor     = '0;
                            n_rec.count      = slab_pkg::blocks_in_page(r_cmd.cls);
                        end
                    end
                    slab_pkg::ACT_FREE, slab_pkg::ACT_QUERY: begin
                        n_page = r_cmd.page;
                        if (w_page_out) begin
                            n_out.status = slab_pkg::ST_BAD_ADDR;
                            out_load     = out_free;
                        end else begin
                            prec_re = 1'b1;
                        end
                    end
                    default: begin
                        out_load = out_free;
                    end
                endcase
            end
            slab_pkg::BS_RD: begin
                rec_load = 1'b1;
                n_rec    = r_prec_q;
            end
            slab_pkg::BS_WORK, slab_pkg::BS_LINK: begin
                case (r_cmd.action)
                    slab_pkg::ACT_ALLOC: begin
                        if (r_state == slab_pkg::BS_WORK && w_has_freed) begin
                            blk_re = 1'b1;
                        end else begin
                            out_load            = out_free;
                            n_out.status        = slab_pkg::ST_DONE;
                            n_out.block_address = w_aaddr;
                            prec_wdata          = r_rec;
                            if (r_state == slab_pkg::BS_LINK) begin
                                prec_wdata.free_top = r_blk_q;
                            end else begin
                                prec_wdata.cursor = r_rec.cursor + IW'(1);
                            end
                            prec_wdata.count = w_cnt_dec;
                            head_val  = w_h;
                            head_vval = w_hv;
                            if (w_cnt_dec != '0) begin
                                // page stays on its list, at the head
                                prec_wdata.link       = w_h;
                                prec_wdata.link_valid = w_hv;
                                head_val              = r_page;
                                head_vval             = 1'b1;
                            end
                            prec_we = out_free;
                            head_we = out_free;
                        end
                    end
                    slab_pkg::ACT_FREE: begin
                        out_load          = out_free;
                        n_out.owned       = 1'b1;
                        n_out.block_bytes = w_esize;
                        if (!w_free_ok) begin
                            n_out.status = slab_pkg::ST_BAD_ADDR;
                        end else begin
                            n_out.status        = slab_pkg::ST_DONE;
                            blk_we              = out_free;
                            prec_we             = out_free;
                            prec_wdata.free_top = w_fidx;
                            prec_wdata.count    = r_rec.count + IW'(1);
                            if (r_rec.count == '0) begin
                                // relink a page that was full
                                prec_wdata.link       = r_head[w_cls];
                                prec_wdata.link_valid = r_head_v[w_cls];
                                head_val              = r_page;
                                head_vval             = 1'b1;
                                head_we               = out_free;
                            end
                        end
                    end
                    default: begin
                        out_load          = out_free;
                        n_out.status      = slab_pkg::ST_DONE;
                        n_out.owned       = 1'b1;
                        n_out.block_bytes = w_esize;
                    end
                endcase
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (prec_we) begin
            m_prec[r_page] <= prec_wdata;
        end
        if (prec_re) begin
            r_prec_q <= m_prec[prec_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (blk_we) begin
            m_blk[blk_waddr] <= blk_wdata;
        end
        if (blk_re) begin
            r_blk_q <= m_blk[blk_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (rec_load) begin
            r_rec <= n_rec;
        end
        r_page      <= n_page;
        r_from_list <= n_from_list;
        if (out_load) begin
            r_out <= n_out;
        end
        if (head_we) begin
            r_head[head_cls] <= head_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= slab_pkg::BS_IDLE;
            r_pages_taken <= '0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < slab_pkg::NUM_CLASSES; i++) begin
                r_head_v[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (taken_inc) begin
                r_pages_taken <= r_pages_taken + slab_pkg::TAKEN_W'(1);
            end
            if (head_we) begin
                r_head_v[head_cls] <= head_vval;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ sv/slab_block_allocator_top.sv @@
// Slab allocator over 64 pages of 4096 bytes with six size classes (8 to 64 bytes).
// The back part handles one item at a time: it takes the item from the queue and
// decodes it, answering from the decode state for a refused size, an exhausted pool,
// an address outside the slab pages or an ignored action. An allocate from a fresh
// page goes straight to the work state; an allocate from a listed page, a free or a
// query first reads the page record memory; an allocate that reuses a freed block
// also reads the block link memory. Each memory has one port. A two-entry queue in
// front keeps accepting items meanwhile, and the result register lets the next item
// start while a result waits. No clearing pass after reset. Depends on slab_pkg.
module slab_block_allocator_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  slab_pkg::t_in   i_in_item,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output slab_pkg::t_out  o_out_item
);

    logic           cmd_valid;
    logic           cmd_pop;
    slab_pkg::t_cmd cmd;

    slab_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_item      (i_in_item),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd)
    );

    slab_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out_item)
    );

endmodule

@@ sv/slab_checker.sv @@
// Port-level checks for the slab allocator top level, attached by bind.
// Depends on slab_pkg and slab_block_allocator_top.
module slab_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input slab_pkg::t_out  o_out_item
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // the queue fills only from an accepted item
    a_stall_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && !o_in_stall))
        else $error("input stall rose without an accepted item");

    // an allocated address never comes with ownership fields
    a_alloc_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.block_address != '0) |->
        (o_out_item.status == slab_pkg::ST_DONE) && !o_out_item.owned &&
        (o_out_item.block_bytes == '0))
        else $error("allocate result mixes fields");

    // class size is reported exactly when the page is owned
    a_owned_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.owned == (o_out_item.block_bytes != '0)))
        else $error("owned and block_bytes disagree");

    // drop any result after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind slab_block_allocator_top slab_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

@@ sim/slab_checker.sv @@
// Scoreboard for the slab block allocator: watches both channels, predicts each
// result from its own model of the page pool and compares. Depends on slab_pkg.
`timescale 1ns / 1ps

module slab_scoreboard (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  slab_pkg::t_in  i_in_item,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  slab_pkg::t_out i_out_item,
    output int             o_fail_count,
    output int             o_pending
);

    localparam int LINKS = slab_pkg::PAGE_BYTES / 8;

    logic [slab_pkg::PAGE_W-1:0] head_page [slab_pkg::NUM_CLASSES];
    logic                        head_ok   [slab_pkg::NUM_CLASSES];
    logic [slab_pkg::PAGE_W-1:0] next_page [slab_pkg::NUM_PAGES];
    logic                        next_ok   [slab_pkg::NUM_PAGES];
    logic [slab_pkg::CLS_W-1:0]  pg_cls    [slab_pkg::NUM_PAGES];
    logic [slab_pkg::IDX_W-1:0]  pg_top    [slab_pkg::NUM_PAGES];
    logic [slab_pkg::IDX_W-1:0]  pg_cursor [slab_pkg::NUM_PAGES];
    logic [slab_pkg::IDX_W-1:0]  pg_avail  [slab_pkg::NUM_PAGES];
    logic [slab_pkg::IDX_W-1:0]  freed_next [slab_pkg::NUM_PAGES*LINKS];
    int                          slab_pages;
    slab_pkg::t_out              expected_results [$];

    function automatic logic [6:0] cls_size(input logic [slab_pkg::CLS_W-1:0] c);
        case (c)
            3'd0: return 7'd8;   3'd1: return 7'd16;  3'd2: return 7'd24;
            3'd3: return 7'd32;  3'd4: return 7'd48;  default: return 7'd64;
        endcase
    endfunction

    function automatic int cls_blocks(input logic [slab_pkg::CLS_W-1:0] c);
        return (slab_pkg::PAGE_BYTES - slab_pkg::HDR_BYTES) / int'(cls_size(c));
    endfunction

    function automatic void link_page(input int c, input int p);
        next_page[p] = head_page[c];
        next_ok[p]   = head_ok[c];
        head_page[c] = slab_pkg::PAGE_W'(p);
        head_ok[c]   = 1'b1;
    endfunction

    function automatic slab_pkg::t_out serve(input slab_pkg::t_in it);
        slab_pkg::t_out r;
        int c, p, n, idx, ofs, rel, esz;
        r = '0;
        p = it.address / slab_pkg::PAGE_BYTES;
        ofs = it.address % slab_pkg::PAGE_BYTES;
        case (slab_pkg::t_action'(it.action))
            slab_pkg::ACT_ALLOC: begin
                if (it.size > slab_pkg::MAX_ALLOC) begin
                    r.status = slab_pkg::ST_TOO_LARGE;
                    return r;
                end
                c = it.size <= 8 ? 0 : it.size <= 16 ? 1 : it.size <= 24 ? 2 :
                    it.size <= 32 ? 3 : it.size <= 48 ? 4 : 5;
                n = cls_blocks(slab_pkg::CLS_W'(c));
                if (head_ok[c]) begin
                    p = head_page[c];
                    head_page[c] = next_page[p];
                    head_ok[c] = next_ok[p];
                end else begin
                    if (slab_pages >= slab_pkg::NUM_PAGES) begin
                        r.status = slab_pkg::ST_NO_PAGE;
                        return r;
                    end
                    p = slab_pages;
                    slab_pages++;
                    pg_cls[p] = slab_pkg::CLS_W'(c);
                    pg_top[p] = '0;
                    pg_cursor[p] = '0;
                    pg_avail[p] = slab_pkg::IDX_W'(n);
                    next_ok[p] = 1'b0;
                end
                if (int'(pg_avail[p]) - (n - int'(pg_cursor[p])) > 0) begin
                    idx = pg_top[p];
                    pg_top[p] = freed_next[p*LINKS + idx];
                end else begin
                    idx = pg_cursor[p];
                    pg_cursor[p]++;
                end
                pg_avail[p]--;
                if (pg_avail[p] != 0) link_page(c, p);
                r.status = slab_pkg::ST_DONE;
                r.block_address = slab_pkg::ADDR_W'(p*slab_pkg::PAGE_BYTES +
                    slab_pkg::HDR_BYTES + idx*int'(cls_size(slab_pkg::CLS_W'(c))));
            end
            slab_pkg::ACT_FREE: begin
                if (p >= slab_pages) begin
                    r.status = slab_pkg::ST_BAD_ADDR;
                    return r;
                end
                c = pg_cls[p];
                esz = cls_size(slab_pkg::CLS_W'(c));
                r.owned = 1'b1;
                r.block_bytes = 7'(esz);
                if (ofs < slab_pkg::HDR_BYTES) begin
                    r.status = slab_pkg::ST_BAD_ADDR;
                    return r;
                end
                rel = ofs - slab_pkg::HDR_BYTES;
                idx = rel / esz;
                if (rel % esz != 0 || idx >= pg_cursor[p] ||
                    pg_avail[p] >= cls_blocks(slab_pkg::CLS_W'(c))) begin
                    r.status = slab_pkg::ST_BAD_ADDR;
                    return r;
                end
                freed_next[p*LINKS + idx] = pg_top[p];
                pg_top[p] = slab_pkg::IDX_W'(idx);
                pg_avail[p]++;
                if (pg_avail[p] == 1) link_page(c, p);
                r.status = slab_pkg::ST_DONE;
            end
            slab_pkg::ACT_QUERY: begin
                if (p >= slab_pages) begin
                    r.status = slab_pkg::ST_BAD_ADDR;
                    return r;
                end
                r.status = slab_pkg::ST_DONE;
                r.owned = 1'b1;
                r.block_bytes = cls_size(pg_cls[p]);
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        slab_pkg::t_out want;
        if (!i_rst_n) begin
            for (int k = 0; k < slab_pkg::NUM_CLASSES; k++) head_ok[k] = 1'b0;
            slab_pages = 0;
            o_fail_count <= 0;
            o_pending <= 0;
            expected_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(serve(i_in_item));
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result %h", i_out_item);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.status != i_out_item.status ||
                        want.block_address != i_out_item.block_address ||
                        want.owned != i_out_item.owned ||
                        want.block_bytes != i_out_item.block_bytes) begin
                        if (o_fail_count < 10)
                            $display({"mismatch: expected st=%0d addr=%h own=%0d bytes=%0d,",
                                      " got st=%0d addr=%h own=%0d bytes=%0d"},
                                want.status, want.block_address, want.owned,
                                want.block_bytes, i_out_item.status,
                                i_out_item.block_address, i_out_item.owned,
                                i_out_item.block_bytes);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= expected_results.size();
        end
    end
endmodule

@@ sim/tb.sv @@
// Testbench top for the slab block allocator: drives allocate, free and query
// items with random gaps and stalls. Depends on slab_pkg, slab_block_allocator_top and slab_scoreboard.
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    slab_pkg::t_in  in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    slab_pkg::t_out out_item;
    int   fail_count, pending, idle_cycles;
    logic sending_done = 1'b0;
    logic hold_off = 1'b0;
    logic [slab_pkg::ADDR_W-1:0] handed_out [$];

    always #5 i_clk = ~i_clk;

    slab_block_allocator_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_item(out_item)
    );

    slab_scoreboard u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Record addresses handed out so later frees hit real blocks.
    always @(posedge i_clk)
        if (out_valid && !out_stall && out_item.status == slab_pkg::ST_DONE &&
            out_item.block_address != 0)
            handed_out.push_back(out_item.block_address);

    task automatic send(input slab_pkg::t_action act, input logic [7:0] sz,
                        input logic [slab_pkg::ADDR_W-1:0] addr, input logic gaps);
        int gap;
        gap = gaps && $urandom_range(3) == 0 ? $urandom_range(19) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{action: act, size: sz, address: addr};
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic send_random(input logic gaps);
        int pick, k;
        logic [slab_pkg::ADDR_W-1:0] a;
        pick = $urandom_range(99);
        if (pick < 45)
            send(slab_pkg::ACT_ALLOC, pick < 3 ? 8'($urandom) : 8'($urandom_range(64)),
                 '0, gaps);
        else if (pick < 80 && handed_out.size() > 0) begin
            k = $urandom_range(handed_out.size() - 1);
            a = handed_out[k];
            handed_out.delete(k);
            send(slab_pkg::ACT_FREE, 8'($urandom), a, gaps);
        end else if (pick < 90)
            send(slab_pkg::ACT_QUERY, 8'($urandom), 18'($urandom), gaps);
        else
            send(slab_pkg::t_action'($urandom_range(3)), 8'($urandom), 18'($urandom), gaps);
    endtask

    // Receiver: a random wait before each item, and one long hold-off.
    initial begin
        int wait_n;
        bit held;
        held = 1'b0;
        @(posedge i_rst_n);
        while (!sending_done) begin
            if (hold_off && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
            end else begin
                wait_n = $urandom_range(19);
                if (wait_n != 0) begin
                    out_stall <= 1'b1;
                    repeat (wait_n) @(posedge i_clk);
                end
                out_stall <= 1'b0;
                do @(posedge i_clk);
                while (!out_valid && !sending_done && !(hold_off && !held));
            end
        end
        out_stall <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("[slab_block_allocator_top] ERROR");
            $finish;
        end
    end

    initial begin
        logic [7:0] sizes [10] = '{8'd0, 8'd1, 8'd8, 8'd16, 8'd24, 8'd32, 8'd48,
                                   8'd64, 8'd65, 8'd255};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: every size class, refused sizes, bad frees and queries.
        foreach (sizes[k]) send(slab_pkg::ACT_ALLOC, sizes[k], '0, 1'b0);
        send(slab_pkg::ACT_FREE, '0, 18'h3FFFF, 1'b0);       // outside slab pages
        send(slab_pkg::ACT_FREE, '0, 18'd0, 1'b0);           // header
        send(slab_pkg::ACT_FREE, '0, 18'd41, 1'b0);          // not on block start
        send(slab_pkg::ACT_FREE, '0, 18'd40 + 18'd8 * 18'd100, 1'b0); // never handed out
        send(slab_pkg::ACT_FREE, 8'hFF, 18'd40, 1'b0);       // valid free
        send(slab_pkg::ACT_FREE, '0, 18'd40, 1'b0);          // double free
        send(slab_pkg::ACT_ALLOC, 8'd3, '0, 1'b0);           // reuse freed block
        send(slab_pkg::ACT_QUERY, '0, 18'd4096, 1'b0);
        send(slab_pkg::ACT_QUERY, '0, 18'h3FFFF, 1'b0);
        send(slab_pkg::ACT_NONE, 8'hFF, 18'h3FFFF, 1'b0);
        // Fill a 64-byte page so it leaves its list, then free into it.
        repeat (70) send(slab_pkg::ACT_ALLOC, 8'd64, '0, 1'b0);
        send(slab_pkg::ACT_FREE, '0, 18'd5 * 18'd4096 + 18'd40, 1'b0);
        // Burst while the receiver holds off to fill the block.
        hold_off <= 1'b1;
        repeat (30) send_random(1'b0);
        for (int n = 0; n < 650; n++) send_random(n % 200 >= 150 ? 1'b0 : 1'b1);
        // Exhaust the pool.
        repeat (80) send(slab_pkg::ACT_ALLOC, 8'($urandom_range(64)), '0, 1'b0);
        repeat (60) send(slab_pkg::ACT_ALLOC, 8'd64, '0, 1'b1);
        in_valid <= 1'b0;
        sending_done <= 1'b1;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[slab_block_allocator_top] OK");
        else
            $display("[slab_block_allocator_top] ERROR");
        $finish;
    end
endmodule
